### rtl/assert_macros.svh
// Assertion macros used by the matcher engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge out of reset.
`define CHK_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Types, codes and defaults shared by the limit order book matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package lobm_pkg;

   localparam int PRICE_LEVELS_DEF   = 256;
   localparam int ORDER_CAPACITY_DEF = 32;
   localparam int ID_BITS_DEF        = 32;

   localparam logic [1:0] ST_RESTED = 2'd0;
   localparam logic [1:0] ST_FILLED = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_ZERO   = 2'd3;

   localparam logic KIND_TRADE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   typedef struct packed {
      logic        side;
      logic [7:0]  price_tick;
      logic [15:0] quantity;
      logic [31:0] order_id;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] buy_order_id;
      logic [31:0] sell_order_id;
      logic [7:0]  buy_price;
      logic [7:0]  sell_price;
      logic [15:0] trade_quantity;
      logic        buy_filled;
      logic        sell_filled;
      logic [1:0]  final_status;
      logic [31:0] trade_count;
      logic        last;
   } rsp_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_ALLOC, S_PLACE, S_LVL_UPD, S_LINK_WR, S_MCHK,
      S_M_BL, S_M_SL, S_M_BO, S_M_SO, S_M_SW, S_FREE_B, S_FREE_S,
      S_RSB_RD, S_RSB_CK, S_RSA_RD, S_RSA_CK, S_STATUS
   } state_type;

endpackage

`default_nettype wire

### rtl/lobm_out_reg.sv
// ----------------------------------------------------------------------------
// lobm_out_reg
// One-entry output register between the engine and the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_out_reg
   import lobm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         free,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign free      = !valid_ff || rsp_ready;
   assign valid_in  = push || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (push) begin
         data_ff <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/lobm_engine.sv
// ----------------------------------------------------------------------------
// lobm_engine
// Sequencer over the order store and the level table memories: insert,
// match queue heads, free slots, rescan for the next best level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lobm_engine
   import lobm_pkg::*;
#(
   parameter int PRICE_LEVELS   = PRICE_LEVELS_DEF,
   parameter int ORDER_CAPACITY = ORDER_CAPACITY_DEF,
   parameter int ID_BITS        = ID_BITS_DEF
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         out_push,
   output rsp_type      out_data,
   input  wire logic    out_free
);

   localparam int PB = $clog2(PRICE_LEVELS);
   localparam int LA = PB + 1;
   localparam int SB = $clog2(ORDER_CAPACITY);
   localparam int CB = $clog2(ORDER_CAPACITY + 1);
   localparam int LW = 1 + 2 * SB;
   localparam int OW = ID_BITS + 16 + SB;
   localparam int LD = 2 ** LA;

   // level table
   logic [LW-1:0] lvl_mem [LD];
   logic          lvl_we, lvl_re;
   logic [LA-1:0] lvl_waddr, lvl_raddr;
   logic [LW-1:0] lvl_wdata, lvl_rdata_ff;

   // order store
   logic [OW-1:0] ord_mem [ORDER_CAPACITY];
   logic          ord_we, ord_re;
   logic [SB-1:0] ord_waddr, ord_raddr;
   logic [OW-1:0] ord_wdata, ord_rdata_ff;

   always_ff @(posedge clock) begin
      if (lvl_we) begin
         lvl_mem[lvl_waddr] <= lvl_wdata;
      end
      if (lvl_re) begin
         lvl_rdata_ff <= (lvl_we && lvl_waddr == lvl_raddr) ? lvl_wdata : lvl_mem[lvl_raddr];
      end
      if (ord_we) begin
         ord_mem[ord_waddr] <= ord_wdata;
      end
      if (ord_re) begin
         ord_rdata_ff <= (ord_we && ord_waddr == ord_raddr) ? ord_wdata : ord_mem[ord_raddr];
      end
   end

   state_type     state_ff, state_in;
   logic [LA-1:0] clr_ff, clr_in;
   logic          side_ff, side_in;
   logic [PB-1:0] price_ff, price_in;
   logic [15:0]   qty_ff, qty_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [SB-1:0] slot_ff, slot_in;
   logic          resting_ff, resting_in;
   logic [1:0]    status_ff, status_in;
   logic [CB-1:0] guard_ff, guard_in;
   logic [CB-1:0] alloc_cnt_ff, alloc_cnt_in;
   logic [CB-1:0] list_cnt_ff, list_cnt_in;
   logic [SB-1:0] free_head_ff, free_head_in;
   logic          bid_ok_ff, bid_ok_in, ask_ok_ff, ask_ok_in;
   logic [PB-1:0] best_bid_ff, best_bid_in, best_ask_ff, best_ask_in;
   logic [PB-1:0] scan_ff, scan_in;
   logic [31:0]   trades_ff, trades_in;
   logic [LW-1:0] blvl_ff, blvl_in, slvl_ff, slvl_in;
   logic [OW-1:0] bord_ff, bord_in, sord_ff, sord_in;
   logic          bf_ff, bf_in, sf_ff, sf_in;
   logic          trade_push;

   logic [12:0]   ptick;
   logic [PB-1:0] psat;
   logic [15:0]   bq, sq, mq;

   assign ptick = 13'(req_data.price_tick);
   assign psat  = (ptick >= 13'(PRICE_LEVELS)) ? PB'(PRICE_LEVELS - 1) : PB'(ptick);
   assign bq    = bord_ff[16+SB-1:SB];
   assign sq    = ord_rdata_ff[16+SB-1:SB];
   assign mq    = (bq < sq) ? bq : sq;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      side_in      = side_ff;
      price_in     = price_ff;
      qty_in       = qty_ff;
      id_in        = id_ff;
      slot_in      = slot_ff;
      resting_in   = resting_ff;
      status_in    = status_ff;
      guard_in     = guard_ff;
      alloc_cnt_in = alloc_cnt_ff;
      list_cnt_in  = list_cnt_ff;
      free_head_in = free_head_ff;
      bid_ok_in    = bid_ok_ff;
      ask_ok_in    = ask_ok_ff;
      best_bid_in  = best_bid_ff;
      best_ask_in  = best_ask_ff;
      scan_in      = scan_ff;
      trades_in    = trades_ff;
      blvl_in      = blvl_ff;
      slvl_in      = slvl_ff;
      bord_in      = bord_ff;
      sord_in      = sord_ff;
      bf_in        = bf_ff;
      sf_in        = sf_ff;
      req_ready    = 1'b0;
      out_push     = 1'b0;
      trade_push   = 1'b0;
      out_data     = '0;
      lvl_we       = 1'b0;
      lvl_re       = 1'b0;
      lvl_waddr    = '0;
      lvl_raddr    = '0;
      lvl_wdata    = '0;
      ord_we       = 1'b0;
      ord_re       = 1'b0;
      ord_waddr    = '0;
      ord_raddr    = '0;
      ord_wdata    = '0;

      unique case (state_ff)
         S_CLEAR: begin
            lvl_we    = 1'b1;
            lvl_waddr = clr_ff;
            clr_in    = clr_ff + LA'(1);
            if (clr_ff == LA'(LD - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               side_in    = req_data.side;
               price_in   = psat;
               qty_in     = req_data.quantity;
               id_in      = ID_BITS'(req_data.order_id);
               resting_in = 1'b1;
               guard_in   = '0;
               if (req_data.quantity == 16'd0) begin
                  status_in = ST_ZERO;
                  state_in  = S_STATUS;
               end else if (list_cnt_ff == '0 &&
                            alloc_cnt_ff == CB'(ORDER_CAPACITY)) begin
                  status_in = ST_FULL;
                  state_in  = S_STATUS;
               end else if (list_cnt_ff != '0) begin
                  ord_re    = 1'b1;
                  ord_raddr = free_head_ff;
                  state_in  = S_ALLOC;
               end else begin
                  slot_in      = SB'(alloc_cnt_ff);
                  alloc_cnt_in = alloc_cnt_ff + CB'(1);
                  state_in     = S_PLACE;
               end
            end
         end
         S_ALLOC: begin
            slot_in      = free_head_ff;
            free_head_in = ord_rdata_ff[SB-1:0];
            list_cnt_in  = list_cnt_ff - CB'(1);
            state_in     = S_PLACE;
         end
         S_PLACE: begin
            ord_we    = 1'b1;
            ord_waddr = slot_ff;
            ord_wdata = {id_ff, qty_ff, SB'(0)};
            lvl_re    = 1'b1;
            lvl_raddr = {side_ff, price_ff};
            state_in  = S_LVL_UPD;
         end
         S_LVL_UPD: begin
            lvl_we    = 1'b1;
            lvl_waddr = {side_ff, price_ff};
            if (lvl_rdata_ff[LW-1]) begin
               lvl_wdata = {1'b1, lvl_rdata_ff[2*SB-1:SB], slot_ff};
               ord_re    = 1'b1;
               ord_raddr = lvl_rdata_ff[SB-1:0];
               blvl_in   = lvl_rdata_ff;
               state_in  = S_LINK_WR;
            end else begin
               lvl_wdata = {1'b1, slot_ff, slot_ff};
               state_in  = S_MCHK;
            end
            if (side_ff == SIDE_BUY) begin
               if (!bid_ok_ff || price_ff > best_bid_ff) begin
                  bid_ok_in   = 1'b1;
                  best_bid_in = price_ff;
               end
            end else begin
               if (!ask_ok_ff || price_ff < best_ask_ff) begin
                  ask_ok_in   = 1'b1;
                  best_ask_in = price_ff;
               end
            end
         end
         S_LINK_WR: begin
            ord_we    = 1'b1;
            ord_waddr = blvl_ff[SB-1:0];
            ord_wdata = {ord_rdata_ff[OW-1:SB], slot_ff};
            state_in  = S_MCHK;
         end
         S_MCHK: begin
            if (guard_ff < CB'(ORDER_CAPACITY) && bid_ok_ff && ask_ok_ff &&
                best_bid_ff >= best_ask_ff) begin
               lvl_re    = 1'b1;
               lvl_raddr = {SIDE_BUY, best_bid_ff};
               state_in  = S_M_BL;
            end else begin
               status_in = resting_ff ? ST_RESTED : ST_FILLED;
               state_in  = S_STATUS;
            end
         end
         S_M_BL: begin
            blvl_in   = lvl_rdata_ff;
            lvl_re    = 1'b1;
            lvl_raddr = {SIDE_SELL, best_ask_ff};
            state_in  = S_M_SL;
         end
         S_M_SL: begin
            slvl_in   = lvl_rdata_ff;
            ord_re    = 1'b1;
            ord_raddr = blvl_ff[2*SB-1:SB];
            state_in  = S_M_BO;
         end
         S_M_BO: begin
            bord_in   = ord_rdata_ff;
            ord_re    = 1'b1;
            ord_raddr = slvl_ff[2*SB-1:SB];
            state_in  = S_M_SO;
         end
         S_M_SO: begin
            if (out_free) begin
               bord_in   = {bord_ff[OW-1:16+SB], bq - mq, bord_ff[SB-1:0]};
               sord_in   = {ord_rdata_ff[OW-1:16+SB], sq - mq, ord_rdata_ff[SB-1:0]};
               bf_in     = (bq == mq);
               sf_in     = (sq == mq);
               ord_we    = 1'b1;
               ord_waddr = blvl_ff[2*SB-1:SB];
               ord_wdata = {bord_ff[OW-1:16+SB], bq - mq, bord_ff[SB-1:0]};
               trades_in = trades_ff + 32'd1;
               guard_in  = guard_ff + CB'(1);
               out_push  = 1'b1;
               trade_push = 1'b1;
               out_data.kind           = KIND_TRADE;
               out_data.buy_order_id   = 32'(bord_ff[OW-1:16+SB]);
               out_data.sell_order_id  = 32'(ord_rdata_ff[OW-1:16+SB]);
               out_data.buy_price      = 8'(best_bid_ff);
               out_data.sell_price     = 8'(best_ask_ff);
               out_data.trade_quantity = mq;
               out_data.buy_filled     = (bq == mq);
               out_data.sell_filled    = (sq == mq);
               out_data.trade_count    = trades_ff + 32'd1;
               state_in = S_M_SW;
            end
         end
         S_M_SW: begin
            ord_we    = 1'b1;
            ord_waddr = slvl_ff[2*SB-1:SB];
            ord_wdata = sord_ff;
            state_in  = S_FREE_B;
         end
         S_FREE_B: begin
            state_in = S_FREE_S;
            if (bf_ff) begin
               if (blvl_ff[2*SB-1:SB] == slot_ff) begin
                  resting_in = 1'b0;
               end
               ord_we       = 1'b1;
               ord_waddr    = blvl_ff[2*SB-1:SB];
               ord_wdata    = {bord_ff[OW-1:SB], free_head_ff};
               free_head_in = blvl_ff[2*SB-1:SB];
               list_cnt_in  = list_cnt_ff + CB'(1);
               lvl_we       = 1'b1;
               lvl_waddr    = {SIDE_BUY, best_bid_ff};
               if (blvl_ff[2*SB-1:SB] == blvl_ff[SB-1:0]) begin
                  lvl_wdata = {1'b0, blvl_ff[2*SB-1:0]};
                  scan_in   = best_bid_ff;
                  state_in  = S_RSB_RD;
               end else begin
                  lvl_wdata = {1'b1, bord_ff[SB-1:0], blvl_ff[SB-1:0]};
               end
            end
         end
         S_RSB_RD: begin
            lvl_re    = 1'b1;
            lvl_raddr = {SIDE_BUY, scan_ff};
            state_in  = S_RSB_CK;
         end
         S_RSB_CK: begin
            if (lvl_rdata_ff[LW-1]) begin
               bid_ok_in   = 1'b1;
               best_bid_in = scan_ff;
               state_in    = S_FREE_S;
            end else if (scan_ff == '0) begin
               bid_ok_in = 1'b0;
               state_in  = S_FREE_S;
            end else begin
               scan_in  = scan_ff - PB'(1);
               state_in = S_RSB_RD;
            end
         end
         S_FREE_S: begin
            state_in = S_MCHK;
            if (sf_ff) begin
               if (slvl_ff[2*SB-1:SB] == slot_ff) begin
                  resting_in = 1'b0;
               end
               ord_we       = 1'b1;
               ord_waddr    = slvl_ff[2*SB-1:SB];
               ord_wdata    = {sord_ff[OW-1:SB], free_head_ff};
               free_head_in = slvl_ff[2*SB-1:SB];
               list_cnt_in  = list_cnt_ff + CB'(1);
               lvl_we       = 1'b1;
               lvl_waddr    = {SIDE_SELL, best_ask_ff};
               if (slvl_ff[2*SB-1:SB] == slvl_ff[SB-1:0]) begin
                  lvl_wdata = {1'b0, slvl_ff[2*SB-1:0]};
                  scan_in   = best_ask_ff;
                  state_in  = S_RSA_RD;
               end else begin
                  lvl_wdata = {1'b1, sord_ff[SB-1:0], slvl_ff[SB-1:0]};
               end
            end
         end
         S_RSA_RD: begin
            lvl_re    = 1'b1;
            lvl_raddr = {SIDE_SELL, scan_ff};
            state_in  = S_RSA_CK;
         end
         S_RSA_CK: begin
            if (lvl_rdata_ff[LW-1]) begin
               ask_ok_in   = 1'b1;
               best_ask_in = scan_ff;
               state_in    = S_MCHK;
            end else if (scan_ff == PB'(PRICE_LEVELS - 1)) begin
               ask_ok_in = 1'b0;
               state_in  = S_MCHK;
            end else begin
               scan_in  = scan_ff + PB'(1);
               state_in = S_RSA_RD;
            end
         end
         S_STATUS: begin
            if (out_free) begin
               out_push              = 1'b1;
               out_data.kind         = KIND_STATUS;
               out_data.final_status = status_ff;
               out_data.trade_count  = trades_ff;
               out_data.last         = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         alloc_cnt_ff <= '0;
         list_cnt_ff  <= '0;
         free_head_ff <= '0;
         bid_ok_ff    <= 1'b0;
         ask_ok_ff    <= 1'b0;
         best_bid_ff  <= '0;
         best_ask_ff  <= '0;
         trades_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         alloc_cnt_ff <= alloc_cnt_in;
         list_cnt_ff  <= list_cnt_in;
         free_head_ff <= free_head_in;
         bid_ok_ff    <= bid_ok_in;
         ask_ok_ff    <= ask_ok_in;
         best_bid_ff  <= best_bid_in;
         best_ask_ff  <= best_ask_in;
         trades_ff    <= trades_in;
      end
      side_ff    <= side_in;
      price_ff   <= price_in;
      qty_ff     <= qty_in;
      id_ff      <= id_in;
      slot_ff    <= slot_in;
      resting_ff <= resting_in;
      status_ff  <= status_in;
      guard_ff   <= guard_in;
      scan_ff    <= scan_in;
      blvl_ff    <= blvl_in;
      slvl_ff    <= slvl_in;
      bord_ff    <= bord_in;
      sord_ff    <= sord_in;
      bf_ff      <= bf_in;
      sf_ff      <= sf_in;
   end

   `CHK_ALWAYS(a_free_list_bound, list_cnt_ff <= alloc_cnt_ff, "free list exceeds used slots")
   `CHK_ALWAYS(a_push_when_free, !out_push || out_free, "push into full output register")
   `CHK_NEXT(a_trade_count, trade_push, trades_ff == $past(trades_ff) + 32'd1, "trade count slip")

endmodule

`default_nettype wire

### rtl/limit_order_book_matcher_top.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_top
// Price-time priority limit order book with trade and status responses.
// ----------------------------------------------------------------------------
// One order request at a time. After reset the level table is swept clear,
// one entry per cycle over 2*PRICE_LEVELS entries (PRICE_LEVELS rounded up to
// a power of two), before the first request is taken. A request enters the
// book and is followed by its status response; each trade adds order store
// and level table accesses, and an emptied best level starts a scan of the
// level table, one price level read at a time, for the next best one.
// Rejected requests go straight to their status response. A stalled response
// channel holds the engine at its next trade or status response.
`default_nettype none

module limit_order_book_matcher_top
   import lobm_pkg::*;
#(
   parameter int PRICE_LEVELS   = PRICE_LEVELS_DEF,
   parameter int ORDER_CAPACITY = ORDER_CAPACITY_DEF,
   parameter int ID_BITS        = ID_BITS_DEF
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    out_push, out_free;
   rsp_type out_data;

   lobm_engine #(
      .PRICE_LEVELS  (PRICE_LEVELS),
      .ORDER_CAPACITY(ORDER_CAPACITY),
      .ID_BITS       (ID_BITS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .out_push (out_push),
      .out_data (out_data),
      .out_free (out_free)
   );

   lobm_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .push     (out_push),
      .push_data(out_data),
      .free     (out_free),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
